### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; ASSERT_OFF compiles them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, masked while reset is held
`define SP_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error(msg);

// clocked check that also runs through reset
`define SP_ASSERT_NR(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`else

`define SP_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define SP_ASSERT_NR(lbl, clk_s, prop, msg)

`endif

`endif

### rtl/segpoly_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segpoly_pkg
// Shared constants and types for the segment versus polygon edge checker.
// ----------------------------------------------------------------------------
package segpoly_pkg;

  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_COORD_BITS   = 16;

  localparam int COUNT_W = 5;   // vertex_count register width
  localparam int SLOT_W  = 4;   // vertex slot field width

  localparam logic [COUNT_W-1:0] MIN_VERTICES = COUNT_W'(3);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  // sideband that travels with an edge through the check pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } edge_ctl_t;

endpackage

### rtl/segpoly_vstore.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segpoly_vstore
// Vertex memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module segpoly_vstore #(
  parameter int DEPTH = 16,
  parameter int CB    = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [CB-1:0] wr_x,
  input  logic signed [CB-1:0] wr_y,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [CB-1:0] rd_x,
  output logic signed [CB-1:0] rd_y
);

  logic signed [CB-1:0] mem_x_r [DEPTH];
  logic signed [CB-1:0] mem_y_r [DEPTH];
  logic signed [CB-1:0] rd_x_r;
  logic signed [CB-1:0] rd_y_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x_r[wr_addr] <= wr_x;
      mem_y_r[wr_addr] <= wr_y;
    end
    if (rd_en) begin
      rd_x_r <= mem_x_r[rd_addr];
      rd_y_r <= mem_y_r[rd_addr];
    end
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule

### rtl/segpoly_edge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segpoly_edge
// Four-stage orientation test of segment p1-p2 against edge q1-q2.
// ----------------------------------------------------------------------------
module segpoly_edge #(
  parameter int CB = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  segpoly_pkg::edge_ctl_t in_ctl,
  input  logic signed [CB-1:0]  p1x,
  input  logic signed [CB-1:0]  p1y,
  input  logic signed [CB-1:0]  p2x,
  input  logic signed [CB-1:0]  p2y,
  input  logic signed [CB-1:0]  q1x,
  input  logic signed [CB-1:0]  q1y,
  input  logic signed [CB-1:0]  q2x,
  input  logic signed [CB-1:0]  q2y,
  output segpoly_pkg::edge_ctl_t out_ctl,
  output logic                  out_hit
);
  import segpoly_pkg::*;

  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;

  localparam logic [1:0] ORI_COLL = 2'd0;
  localparam logic [1:0] ORI_CW   = 2'd1;
  localparam logic [1:0] ORI_CCW  = 2'd2;

  function automatic logic signed [DW-1:0] diff(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
    logic signed [DW-1:0] ae;
    logic signed [DW-1:0] be;
    ae = $signed({a[CB-1], a});
    be = $signed({b[CB-1], b});
    return ae - be;
  endfunction

  // q inside the bounding box spanned by a and b
  function automatic logic in_box(input logic signed [CB-1:0] ax,
                                  input logic signed [CB-1:0] ay,
                                  input logic signed [CB-1:0] qx,
                                  input logic signed [CB-1:0] qy,
                                  input logic signed [CB-1:0] bx,
                                  input logic signed [CB-1:0] by);
    return ((qx <= ax) || (qx <= bx)) && ((qx >= ax) || (qx >= bx)) &&
           ((qy <= ay) || (qy <= by)) && ((qy >= ay) || (qy >= by));
  endfunction

  function automatic logic [1:0] orient(input logic signed [PW-1:0] l,
                                        input logic signed [PW-1:0] r);
    return (l == r) ? ORI_COLL : ((l > r) ? ORI_CW : ORI_CCW);
  endfunction

  // stage 1: differences and box flags
  logic signed [DW-1:0] dpy_r, dpx_r, a1x_r, a1y_r, a2x_r, a2y_r;
  logic signed [DW-1:0] dqy_r, dqx_r, b1x_r, b1y_r, b2x_r, b2y_r;
  logic [3:0]           box_s1_r, box_s2_r, box_s3_r;
  edge_ctl_t            ctl_s1_r, ctl_s2_r, ctl_s3_r, ctl_s4_r;
  // stage 2: cross product halves
  logic signed [PW-1:0] l1_r, r1_r, l2_r, r2_r, l3_r, r3_r, l4_r, r4_r;
  // stage 3: orientations
  logic [1:0]           o1_r, o2_r, o3_r, o4_r;
  // stage 4: edge verdict
  logic                 hit_r;
  logic                 hit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s1_r <= '0;
      ctl_s2_r <= '0;
      ctl_s3_r <= '0;
      ctl_s4_r <= '0;
    end else begin
      ctl_s1_r <= in_ctl;
      ctl_s2_r <= ctl_s1_r;
      ctl_s3_r <= ctl_s2_r;
      ctl_s4_r <= ctl_s3_r;
    end
  end

  always_ff @(posedge clk) begin
    dpy_r <= diff(p2y, p1y);
    dpx_r <= diff(p2x, p1x);
    a1x_r <= diff(q1x, p2x);
    a1y_r <= diff(q1y, p2y);
    a2x_r <= diff(q2x, p2x);
    a2y_r <= diff(q2y, p2y);
    dqy_r <= diff(q2y, q1y);
    dqx_r <= diff(q2x, q1x);
    b1x_r <= diff(p1x, q2x);
    b1y_r <= diff(p1y, q2y);
    b2x_r <= diff(p2x, q2x);
    b2y_r <= diff(p2y, q2y);
    box_s1_r <= {in_box(q1x, q1y, p2x, p2y, q2x, q2y),
                 in_box(q1x, q1y, p1x, p1y, q2x, q2y),
                 in_box(p1x, p1y, q2x, q2y, p2x, p2y),
                 in_box(p1x, p1y, q1x, q1y, p2x, p2y)};

    l1_r <= PW'(dpy_r) * PW'(a1x_r);
    r1_r <= PW'(dpx_r) * PW'(a1y_r);
    l2_r <= PW'(dpy_r) * PW'(a2x_r);
    r2_r <= PW'(dpx_r) * PW'(a2y_r);
    l3_r <= PW'(dqy_r) * PW'(b1x_r);
    r3_r <= PW'(dqx_r) * PW'(b1y_r);
    l4_r <= PW'(dqy_r) * PW'(b2x_r);
    r4_r <= PW'(dqx_r) * PW'(b2y_r);
    box_s2_r <= box_s1_r;

    o1_r <= orient(l1_r, r1_r);
    o2_r <= orient(l2_r, r2_r);
    o3_r <= orient(l3_r, r3_r);
    o4_r <= orient(l4_r, r4_r);
    box_s3_r <= box_s2_r;

    hit_r <= hit_nxt;
  end

  // proper crossing, or a collinear end point lying on the other segment
  always_comb begin
    hit_nxt = ((o1_r != o2_r) && (o3_r != o4_r)) ||
              ((o1_r == ORI_COLL) && box_s3_r[0]) ||
              ((o2_r == ORI_COLL) && box_s3_r[1]) ||
              ((o3_r == ORI_COLL) && box_s3_r[2]) ||
              ((o4_r == ORI_COLL) && box_s3_r[3]);
  end

  assign out_ctl = ctl_s4_r;
  assign out_hit = hit_r;

endmodule

### rtl/segment_polygon_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_polygon_intersect
// Tests a line segment against every edge of a stored closed polygon.
// ----------------------------------------------------------------------------
// Load word: taken while idle, busy stays low, no result; one load per cycle while idle.
// Test word with n = min(vertex_count, MAX_VERTICES) >= 3: the read port walks
//   n + 1 vertices, one per cycle (vertex 0 is read again to close the polygon),
//   through the edge check pipeline; out_valid pulses with the closing edge's
//   verdict and busy drops in that same cycle, so no new test is taken before it.
// Test word with n < 3: out_valid pulses with hit = 0 once the sequencer has passed through ST_SHORT.
// Reset (rst_n low, synchronous) clears the sequencer and vertex_count; the
//   vertex memory is not cleared. The result is a one-cycle strobe, never held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_polygon_intersect #(
  parameter int MAX_VERTICES = segpoly_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = segpoly_pkg::DEF_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_req_type,
  input  logic [segpoly_pkg::SLOT_W-1:0]      in_vertex_slot,
  input  logic signed [COORD_BITS-1:0]        in_first_x,
  input  logic signed [COORD_BITS-1:0]        in_first_y,
  input  logic signed [COORD_BITS-1:0]        in_second_x,
  input  logic signed [COORD_BITS-1:0]        in_second_y,
  // result strobe
  output logic                                out_valid,
  output logic                                out_hit,
  // vertex_count register
  input  logic                                cfg_wr_en,
  input  logic [segpoly_pkg::COUNT_W-1:0]     cfg_wr_data
);
  import segpoly_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;  // too few vertices, answer at once
  localparam logic [1:0] ST_READ  = 2'd2;  // walking the vertex memory
  localparam logic [1:0] ST_DRAIN = 2'd3;  // waiting for the last edge verdict

  logic [1:0]            state_r, state_nxt;
  logic [COUNT_W-1:0]    vcount_r;
  logic [COUNT_W-1:0]    n_r, n_nxt;
  logic [COUNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                  acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r, out_hit_nxt;

  // read tags, registered in step with the memory's registered read data
  logic                  rdv_r, rd_first_r, rd_last_r;

  // segment under test and the previous vertex of the walk
  logic signed [COORD_BITS-1:0] p1x_r, p1y_r, p2x_r, p2y_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;

  logic                  accept;
  logic                  is_test;
  logic [COUNT_W-1:0]    n_eff;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;

  edge_ctl_t             ei_ctl;
  edge_ctl_t             eo_ctl;
  logic                  eo_hit;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign is_test = (in_req_type == REQ_TEST);

  // count beyond the store depth is clamped
  assign n_eff = (32'(vcount_r) > MAX_VERTICES) ? COUNT_W'(MAX_VERTICES) : vcount_r;

  // loads to slots past the store depth are dropped
  assign wr_en = accept && !is_test && (32'(in_vertex_slot) < MAX_VERTICES);

  // last read wraps back to vertex 0 for the closing edge
  assign rd_addr = (rd_cnt_r == n_r) ? '0 : AW'(rd_cnt_r);

  segpoly_vstore #(
    .DEPTH (MAX_VERTICES),
    .CB    (COORD_BITS),
    .AW    (AW)
  ) u_vstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_vertex_slot)),
    .wr_x    (in_first_x),
    .wr_y    (in_first_y),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  // an edge is formed once two vertices have come back
  always_comb begin
    ei_ctl.valid = rdv_r && !rd_first_r;
    ei_ctl.last  = rd_last_r;
  end

  segpoly_edge #(
    .CB (COORD_BITS)
  ) u_edge (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (ei_ctl),
    .p1x     (p1x_r),
    .p1y     (p1y_r),
    .p2x     (p2x_r),
    .p2y     (p2y_r),
    .q1x     (prev_x_r),
    .q1y     (prev_y_r),
    .q2x     (rd_x),
    .q2y     (rd_y),
    .out_ctl (eo_ctl),
    .out_hit (eo_hit)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    rd_cnt_nxt    = rd_cnt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = out_hit_r;
    rd_en         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept && is_test) begin
          n_nxt      = n_eff;
          rd_cnt_nxt = '0;
          acc_nxt    = 1'b0;
          state_nxt  = (n_eff >= MIN_VERTICES) ? ST_READ : ST_SHORT;
        end
      end
      ST_SHORT: begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end
      ST_READ: begin
        rd_en = 1'b1;
        if (rd_cnt_r == n_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_cnt_nxt = rd_cnt_r + COUNT_W'(1);
        end
      end
      ST_DRAIN: begin
        // nothing to issue; the last edge closes the test below
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // OR the edge verdicts; the closing edge posts the result
    if (eo_ctl.valid) begin
      if (eo_ctl.last) begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = acc_r || eo_hit;
        acc_nxt       = 1'b0;
        state_nxt     = ST_IDLE;
      end else begin
        acc_nxt = acc_r || eo_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= '0;
      n_r         <= '0;
      rd_cnt_r    <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
      rdv_r       <= 1'b0;
      rd_first_r  <= 1'b0;
      rd_last_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      out_hit_r   <= out_hit_nxt;
      rdv_r       <= rd_en;
      rd_first_r  <= rd_en && (rd_cnt_r == '0);
      rd_last_r   <= rd_en && (rd_cnt_r == n_r);
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept && is_test) begin
      p1x_r <= in_first_x;
      p1y_r <= in_first_y;
      p2x_r <= in_second_x;
      p2y_r <= in_second_y;
    end
    if (rdv_r) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // one strobe per test, never two in a row
  `SP_ASSERT(a_strobe_single, clk, rst_n, out_valid_r |=> !out_valid_r, "double result strobe")
  // a result only follows a busy cycle
  `SP_ASSERT(a_strobe_after_busy, clk, rst_n, out_valid_r |-> $past(state_r != ST_IDLE), "result without a test")
  // edge verdicts only arrive while a walk is open
  `SP_ASSERT(a_edge_in_walk, clk, rst_n, eo_ctl.valid |-> (state_r == ST_READ || state_r == ST_DRAIN), "stray edge verdict")
  // read counter stays within the closing read
  `SP_ASSERT(a_rd_cnt_range, clk, rst_n, (state_r == ST_READ) |-> (rd_cnt_r <= n_r), "read counter overrun")

endmodule

### tb/tb_segment_polygon_intersect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_polygon_intersect
// Self-checking bench for the segment versus polygon edge checker. A short
// directed table comes first, then random polygons and segments. Every result
// strobe is compared with a typed-in expectation or a behavioral orientation-test model kept here.
// ----------------------------------------------------------------------------
module tb_segment_polygon_intersect;
  import segpoly_pkg::*;

  localparam int NV            = DEF_MAX_VERTICES;
  localparam int CW            = DEF_COORD_BITS;
  localparam int SETTLE_CYCLES = NV + 8;    // settle margin after the longest test
  localparam int STALL_LIMIT   = 2000;      // cycles with no word and no result
  localparam int RANDOM_ITEMS  = 750;
  localparam int GAP_MAX       = 14;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    longint x;
    longint y;
  } pt_t;
  typedef enum int {TURN_NONE, TURN_CW, TURN_CCW} turn_e;
  typedef enum int {CM_SMALL, CM_FULL, CM_EXTREME} coord_mode_e;
  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_TEST} row_kind_e;

  // one directed row; arg is the slot of a load or the value of a count write
  typedef struct packed {
    row_kind_e          kind;
    logic [COUNT_W-1:0] arg;
    coord_t             x1;
    coord_t             y1;
    coord_t             x2;
    coord_t             y2;
    bit                 known;     // expected hit typed in below
    bit                 hit;
  } dir_row_t;

  localparam int NUM_DIR = 22;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    // empty polygon right after reset: never a hit
    '{ROW_TEST, 0,     -5,      0,      5,      0, 1'b1, 1'b0},
    // 200 x 200 square around the origin in slots 0..3
    '{ROW_LOAD, 0,   -100,   -100,      0,      0, 1'b0, 1'b0},
    '{ROW_LOAD, 1,    100,   -100,      0,      0, 1'b0, 1'b0},
    '{ROW_LOAD, 2,    100,    100,      0,      0, 1'b0, 1'b0},
    '{ROW_LOAD, 3,   -100,    100,      0,      0, 1'b0, 1'b0},
    // two corners only: below the minimum, forced miss
    '{ROW_CFG,  2,      0,      0,      0,      0, 1'b0, 1'b0},
    '{ROW_TEST, 15,  -200,      0,    200,      0, 1'b1, 1'b0},
    // triangle, closing edge runs 2 -> 0
    '{ROW_CFG,  3,      0,      0,      0,      0, 1'b0, 1'b0},
    '{ROW_TEST, 0,   -200,      0,    200,      0, 1'b0, 1'b0},
    // full square
    '{ROW_CFG,  4,      0,      0,      0,      0, 1'b0, 1'b0},
    '{ROW_TEST, 0,   -200,      0,    200,      0, 1'b0, 1'b0},
    '{ROW_TEST, 9,    -10,    -10,     10,     10, 1'b0, 1'b0},  // wholly inside
    '{ROW_TEST, 0,    100,    100,    100,    100, 1'b0, 1'b0},  // point on a corner
    '{ROW_TEST, 0,      0,      0,      0,      0, 1'b0, 1'b0},  // point inside
    '{ROW_TEST, 6,   -300,   -100,    300,   -100, 1'b0, 1'b0},  // along the bottom side
    '{ROW_TEST, 0,    200,   -100,    300,   -100, 1'b0, 1'b0},  // same line, past corner
    '{ROW_TEST, 0, -32768, -32768,  32767,  32767, 1'b1, 1'b1},  // full-range diagonal
    '{ROW_TEST, 0, -32768,  32767,  32767,  32767, 1'b1, 1'b0},  // top rim of the plane
    // extreme corners; the second pair of a load is ignored
    '{ROW_LOAD, 15, -32768,  32767,  32767, -32768, 1'b0, 1'b0},
    '{ROW_LOAD, 4,   32767, -32768, -32768,  32767, 1'b0, 1'b0},
    '{ROW_CFG,  5,      0,      0,      0,      0, 1'b0, 1'b0},
    '{ROW_TEST, 10,     0, -32768,      0,  32767, 1'b0, 1'b0}
  };

  localparam coord_t EXTREMES [6] = '{-32768, -32767, -1, 0, 1, 32767};

  // DUT ports; the inputs are all known from time zero
  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic               in_req_type    = REQ_LOAD;
  logic [SLOT_W-1:0]  in_vertex_slot = '0;
  coord_t             in_first_x     = '0;
  coord_t             in_first_y     = '0;
  coord_t             in_second_x    = '0;
  coord_t             in_second_y    = '0;
  logic               out_valid;
  logic               out_hit;
  logic               cfg_wr_en      = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data    = '0;

  // travels with the word: expectation typed in by a directed row
  bit row_hit_known = 1'b0;
  bit row_hit_value = 1'b0;

  // model of the polygon store and the count register
  coord_t             corner_x [NV];
  coord_t             corner_y [NV];
  logic [COUNT_W-1:0] vertex_count_m = '0;

  bit hit_expect_q [$];    // one entry per accepted test word, oldest first

  int errors       = 0;
  int tests_taken  = 0;
  int loads_taken  = 0;
  int hits_seen    = 0;
  int count_writes = 0;
  int clamp_phases = 0;
  int stall_cycles = 0;

  segment_polygon_intersect uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_vertex_slot (in_vertex_slot),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Hit prediction
  // --------------------------------------------------------------------------

  // sign of the cross product (b - a) x (c - b); exact in 64 bits
  function automatic turn_e turn_of(pt_t a, pt_t b, pt_t c);
    longint lhs, rhs;
    lhs = (b.y - a.y) * (c.x - b.x);
    rhs = (b.x - a.x) * (c.y - b.y);
    if (lhs == rhs) return TURN_NONE;
    return (lhs > rhs) ? TURN_CW : TURN_CCW;
  endfunction

  // q lies in the bounding box of a and b
  function automatic bit box_holds(pt_t a, pt_t q, pt_t b);
    return q.x <= ((a.x > b.x) ? a.x : b.x) && q.x >= ((a.x < b.x) ? a.x : b.x) &&
           q.y <= ((a.y > b.y) ? a.y : b.y) && q.y >= ((a.y < b.y) ? a.y : b.y);
  endfunction

  function automatic bit segments_touch(pt_t p1, pt_t p2, pt_t q1, pt_t q2);
    turn_e o1, o2, o3, o4;
    o1 = turn_of(p1, p2, q1);
    o2 = turn_of(p1, p2, q2);
    o3 = turn_of(q1, q2, p1);
    o4 = turn_of(q1, q2, p2);
    // proper crossing
    if (o1 != o2 && o3 != o4) return 1'b1;
    // collinear end points: touch only if inside the other segment's box
    if (o1 == TURN_NONE && box_holds(p1, q1, p2)) return 1'b1;
    if (o2 == TURN_NONE && box_holds(p1, q2, p2)) return 1'b1;
    if (o3 == TURN_NONE && box_holds(q1, p1, q2)) return 1'b1;
    if (o4 == TURN_NONE && box_holds(q1, p2, q2)) return 1'b1;
    return 1'b0;
  endfunction

  // segment against every edge of the stored polygon, closing edge wraps to 0
  function automatic bit predict_hit(coord_t sx0, coord_t sy0, coord_t sx1, coord_t sy1);
    int  n, j;
    pt_t s0, s1, e0, e1;
    n = (vertex_count_m > NV) ? NV : int'(vertex_count_m);   // count saturates
    if (n < int'(MIN_VERTICES)) return 1'b0;                 // no polygon yet
    s0.x = sx0;
    s0.y = sy0;
    s1.x = sx1;
    s1.y = sy1;
    for (int i = 0; i < n; i++) begin
      j    = (i + 1 == n) ? 0 : i + 1;
      e0.x = corner_x[i];
      e0.y = corner_y[i];
      e1.x = corner_x[j];
      e1.y = corner_y[j];
      if (segments_touch(s0, s1, e0, e1)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: one process sees both accepted words and result strobes, so the
  // order of pushes and pops never depends on scheduling.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bit expected_hit;
    if (rst_n) begin
      stall_cycles++;
      if (out_valid) begin
        stall_cycles = 0;
        if (hit_expect_q.size() == 0) begin
          $error("out_hit: strobe with no test outstanding, actual %0b", out_hit);
          errors++;
        end else begin
          expected_hit = hit_expect_q.pop_front();
          if (out_hit !== expected_hit) begin
            $error("out_hit mismatch: expected %0b, actual %0b", expected_hit, out_hit);
            errors++;
          end
          if (out_hit === 1'b1) hits_seen++;
        end
      end
      if (start && !busy) begin
        stall_cycles = 0;
        if (in_req_type == REQ_LOAD) begin
          corner_x[in_vertex_slot] = in_first_x;
          corner_y[in_vertex_slot] = in_first_y;
          loads_taken++;
        end else begin
          expected_hit = row_hit_known ? row_hit_value :
                         predict_hit(in_first_x, in_first_y, in_second_x, in_second_y);
          hit_expect_q = {hit_expect_q, expected_hit};
          tests_taken++;
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without a word or a result", STALL_LIMIT);
        $display("tb_segment_polygon_intersect NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------

  // present one word and hold it until taken; start is left high on return
  task automatic send_word(logic req, logic [SLOT_W-1:0] slot, coord_t x1, coord_t y1,
                           coord_t x2, coord_t y2, bit known, bit known_hit);
    start          <= 1'b1;
    in_req_type    <= req;
    in_vertex_slot <= slot;
    in_first_x     <= x1;
    in_first_y     <= y1;
    in_second_x    <= x2;
    in_second_y    <= y2;
    row_hit_known  <= known;
    row_hit_value  <= known_hit;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // stop sending until every test has answered, then let the last one retire
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (hit_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_count(logic [COUNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    vertex_count_m  = value;
    count_writes++;
  endtask

  function automatic coord_t rand_coord(coord_mode_e mode);
    case (mode)
      CM_SMALL: return coord_t'(int'($urandom_range(0, 256)) - 128);
      CM_FULL:  return coord_t'($urandom_range(0, 65535));
      default:  return EXTREMES[$urandom_range(0, 5)];
    endcase
  endfunction

  function automatic bit fits_coord(longint v);
    return v >= -32768 && v <= 32767;
  endfunction

  // random segment, biased toward the stored polygon's corners and edge lines
  task automatic random_test(coord_mode_e mode);
    int     n, i, j;
    longint t0, t1, ax, ay, dx, dy, px, py, qx, qy;
    coord_t x1, y1, x2, y2;
    n = (vertex_count_m > NV) ? NV : int'(vertex_count_m);
    if (n < int'(MIN_VERTICES)) n = NV;    // every slot holds a corner by now
    i  = $urandom_range(0, n - 1);
    j  = (i + 1 == n) ? 0 : i + 1;
    x1 = rand_coord(mode);
    y1 = rand_coord(mode);
    x2 = rand_coord(mode);
    y2 = rand_coord(mode);
    case ($urandom_range(0, 5))
      0: ;                                      // free segment
      1: begin                                  // starts on a corner
        x1 = corner_x[i];
        y1 = corner_y[i];
      end
      2: begin                                  // exactly one edge, either way round
        if ($urandom_range(0, 1)) begin
          x1 = corner_x[i]; y1 = corner_y[i]; x2 = corner_x[j]; y2 = corner_y[j];
        end else begin
          x1 = corner_x[j]; y1 = corner_y[j]; x2 = corner_x[i]; y2 = corner_y[i];
        end
      end
      3: begin                                  // zero-length segment
        if ($urandom_range(0, 1)) begin
          x1 = corner_x[i];
          y1 = corner_y[i];
        end
        x2 = x1;
        y2 = y1;
      end
      default: begin
        // on the edge's line: from one step before the edge (touching or
        // overlapping) or from past its far end (disjoint)
        ax = corner_x[i];
        ay = corner_y[i];
        dx = longint'(corner_x[j]) - ax;
        dy = longint'(corner_y[j]) - ay;
        t0 = $urandom_range(0, 1) ? -1 : 2;
        t1 = t0 + 1 + longint'(int'($urandom_range(0, 2)));
        px = ax + t0 * dx;
        py = ay + t0 * dy;
        qx = ax + t1 * dx;
        qy = ay + t1 * dy;
        if (fits_coord(px) && fits_coord(py) && fits_coord(qx) && fits_coord(qy)) begin
          x1 = coord_t'(px); y1 = coord_t'(py); x2 = coord_t'(qx); y2 = coord_t'(qy);
        end else begin
          x1 = corner_x[j];
          y1 = corner_y[j];
        end
      end
    endcase
    send_word(REQ_TEST, SLOT_W'($urandom_range(0, NV - 1)), x1, y1, x2, y2, 1'b0, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          items, phase, gap_max, n_items, value, fill;
    coord_mode_e pmode;
    dir_row_t    row;
    items = 0;
    phase = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, back to back; count writes wait for an idle block
    for (int r = 0; r < NUM_DIR; r++) begin
      row = DIR_ROWS[r];
      case (row.kind)
        ROW_CFG: begin
          drain_results();
          write_count(row.arg);
        end
        ROW_LOAD: send_word(REQ_LOAD, row.arg[SLOT_W-1:0], row.x1, row.y1, row.x2, row.y2,
                            1'b0, 1'b0);
        default:  send_word(REQ_TEST, row.arg[SLOT_W-1:0], row.x1, row.y1, row.x2, row.y2,
                            row.known, row.hit);
      endcase
    end

    // random phases: new count, often a fresh polygon, then a burst of words.
    // Phase 0 fills every slot so later segments may use any corner; the
    // first few phases pin the count extremes, saturation among them.
    while (items < RANDOM_ITEMS) begin
      drain_results();
      case (phase)
        0:       value = 31;
        1:       value = NV;
        2:       value = 0;
        3:       value = int'(MIN_VERTICES);
        4:       value = NV + 1;
        5:       value = 1;
        default: value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(3, NV);
      endcase
      write_count(COUNT_W'(value));
      if (value > NV) clamp_phases++;

      case ($urandom_range(0, 5))
        0:       pmode = CM_FULL;
        1:       pmode = CM_EXTREME;
        default: pmode = CM_SMALL;
      endcase
      if (phase == 0) pmode = CM_SMALL;
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;   // some phases never idle

      fill = (phase == 0) ? NV : ($urandom_range(0, 1) ? ((value > NV) ? NV : value) : 0);
      for (int k = 0; k < fill; k++) begin
        send_word(REQ_LOAD, SLOT_W'(k), rand_coord(pmode), rand_coord(pmode),
                  rand_coord(CM_FULL), rand_coord(CM_FULL), 1'b0, 1'b0);
        pause_sender($urandom_range(0, gap_max));
        items++;
      end
      // corner picks below read the model store, so let the loads land first
      if (fill > 0) drain_results();

      n_items = $urandom_range(20, 40);
      repeat (n_items) begin
        if ($urandom_range(0, 9) == 0)
          send_word(REQ_LOAD, SLOT_W'($urandom_range(0, NV - 1)), rand_coord(pmode),
                    rand_coord(pmode), rand_coord(CM_FULL), rand_coord(CM_FULL), 1'b0, 1'b0);
        else
          random_test(($urandom_range(0, 4) < 3) ? pmode
                                                 : coord_mode_e'($urandom_range(0, 2)));
        items++;
        // now and then hold off until the block has answered everything
        if ($urandom_range(0, 39) == 0) drain_results();
        else pause_sender($urandom_range(0, gap_max));
      end
      phase++;
    end

    drain_results();
    if (hit_expect_q.size() != 0) begin
      $error("%0d tests never answered", hit_expect_q.size());
      errors++;
    end
    $display("Covered %0d segment tests (%0d hits) and %0d corner loads in %0d random phases",
             tests_taken, hits_seen, loads_taken, phase);
    $display("Vertex count written %0d times, %0d phases with it above the limit",
             count_writes, clamp_phases);
    if (errors == 0) begin
      $display("tb_segment_polygon_intersect OK");
    end else begin
      $display("tb_segment_polygon_intersect NOT OK");
    end
    $finish;
  end

endmodule
